FILE: src/spicmd_pkg.sv
// ----------------------------------------------------------------------------
// SPI command master package
// Shared types, codes and reset values of the SPI command handshake master.
// ----------------------------------------------------------------------------
package spicmd_pkg;

    // Protocol bytes on the SPI wire.
    localparam logic [7:0] CODE_STX = 8'h02;
    localparam logic [7:0] CODE_ENQ = 8'h05;
    localparam logic [7:0] CODE_ACK = 8'h06;
    localparam logic [7:0] CHECKSUM_BASE = 8'hFF;

    // Longest read reply or write payload.
    localparam logic [7:0] MAX_LENGTH = 8'd255;

    // Item kinds.
    localparam logic FUNC_START    = 1'b0;
    localparam logic FUNC_EXCHANGE = 1'b1;

    // Completion status codes.
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_HS_FAIL     = 2'd1;
    localparam logic [1:0] STATUS_NO_ACK      = 2'd2;
    localparam logic [1:0] STATUS_UNKNOWN_CMD = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_READ_CODE   = 2'd0;
    localparam logic [1:0] REG_WRITE1_CODE = 2'd1;
    localparam logic [1:0] REG_WRITE2_CODE = 2'd2;
    localparam logic [1:0] REG_TRY_LIMIT   = 2'd3;

    // Configuration reset values.
    localparam logic [7:0]  RST_READ_CODE   = 8'd1;
    localparam logic [7:0]  RST_WRITE1_CODE = 8'd2;
    localparam logic [7:0]  RST_WRITE2_CODE = 8'd3;
    localparam logic [12:0] RST_TRY_LIMIT   = 13'd4096;

    typedef struct packed {
        logic [7:0]  read_code;
        logic [7:0]  write1_code;
        logic [7:0]  write2_code;
        logic [12:0] try_limit;
    } cfg_t;

    typedef struct packed {
        logic       func;
        logic [7:0] command_byte;
        logic [7:0] byte_count;
        logic [7:0] received_byte;
        logic [7:0] payload_byte;
    } item_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       read_valid;
        logic [7:0] read_data;
        logic [7:0] read_index;
        logic       done_res;
        logic [1:0] status;
        logic       checksum_ok;
    } result_t;

endpackage

FILE: src/spicmd_cfg_regs.sv
// ----------------------------------------------------------------------------
// SPI command master configuration registers
// APB-style register file holding command codes and the handshake try limit.
// ----------------------------------------------------------------------------
module spicmd_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output spicmd_pkg::cfg_t    cfg
);
    import spicmd_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_code   <= RST_READ_CODE;
            cfg_reg.write1_code <= RST_WRITE1_CODE;
            cfg_reg.write2_code <= RST_WRITE2_CODE;
            cfg_reg.try_limit   <= RST_TRY_LIMIT;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_READ_CODE:   cfg_reg.read_code   <= pwdata[7:0];
                REG_WRITE1_CODE: cfg_reg.write1_code <= pwdata[7:0];
                REG_WRITE2_CODE: cfg_reg.write2_code <= pwdata[7:0];
                REG_TRY_LIMIT:   cfg_reg.try_limit   <= pwdata[12:0];
                default:         cfg_reg.try_limit   <= cfg_reg.try_limit;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        case (reg_index)
            REG_READ_CODE:   prdata = {24'd0, cfg_reg.read_code};
            REG_WRITE1_CODE: prdata = {24'd0, cfg_reg.write1_code};
            REG_WRITE2_CODE: prdata = {24'd0, cfg_reg.write2_code};
            REG_TRY_LIMIT:   prdata = {19'd0, cfg_reg.try_limit};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

FILE: src/spicmd_step.sv
// ----------------------------------------------------------------------------
// SPI command master sequencer
// Command state and the single-pass logic that turns one beat into a result.
// ----------------------------------------------------------------------------
module spicmd_step
#(
    parameter logic [7:0] MAX_LEN = spicmd_pkg::MAX_LENGTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  spicmd_pkg::cfg_t    cfg,
    input  spicmd_pkg::item_t   item,
    output spicmd_pkg::result_t res
);
    import spicmd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_STX,
        PH_CMD,
        PH_ENQ,
        PH_READ,
        PH_WPAY,
        PH_WENQ
    } phase_t;

    typedef enum logic [1:0] {
        KIND_READ,
        KIND_WRITE,
        KIND_UNKNOWN
    } kind_t;

    phase_t      phase_reg,    phase_next;
    logic [12:0] try_reg,      try_next;
    logic [7:0]  pos_reg,      pos_next;
    logic [7:0]  length_reg,   length_next;
    kind_t       kind_reg,     kind_next;
    logic [7:0]  command_reg,  command_next;
    logic [7:0]  sum_reg,      sum_next;

    logic [8:0]  pos_inc;
    logic [12:0] try_inc;
    logic [7:0]  expect_sum;

    assign pos_inc    = {1'b0, pos_reg} + 9'd1;
    assign try_inc    = try_reg + 13'd1;
    assign expect_sum = CHECKSUM_BASE - sum_reg;

    // Next state and result for the beat in the input register.
    always_comb
    begin
        phase_next   = phase_reg;
        try_next     = try_reg;
        pos_next     = pos_reg;
        length_next  = length_reg;
        kind_next    = kind_reg;
        command_next = command_reg;
        sum_next     = sum_reg;
        res          = '0;

        if (item.func == FUNC_START)
        begin
            if (phase_reg == PH_IDLE)
            begin
                command_next = item.command_byte;
                if (item.command_byte == cfg.read_code)
                begin
                    kind_next = KIND_READ;
                end
                else if (item.command_byte == cfg.write1_code
                         || item.command_byte == cfg.write2_code)
                begin
                    kind_next = KIND_WRITE;
                end
                else
                begin
                    kind_next = KIND_UNKNOWN;
                end
                length_next    = (item.byte_count > MAX_LEN) ? MAX_LEN : item.byte_count;
                try_next       = '0;
                pos_next       = '0;
                sum_next       = '0;
                phase_next     = PH_STX;
                res.send_valid = 1'b1;
                res.send_byte  = CODE_STX;
            end
        end
        else
        begin
            case (phase_reg)
                PH_STX:
                begin
                    phase_next     = PH_CMD;
                    res.send_valid = 1'b1;
                    res.send_byte  = command_reg;
                end
                PH_CMD:
                begin
                    phase_next     = PH_ENQ;
                    res.send_valid = 1'b1;
                    res.send_byte  = CODE_ENQ;
                end
                PH_ENQ:
                begin
                    if (item.received_byte == CODE_ACK)
                    begin
                        pos_next = '0;
                        sum_next = '0;
                        case (kind_reg)
                            KIND_READ:
                            begin
                                if (length_reg == 8'd0)
                                begin
                                    phase_next   = PH_IDLE;
                                    res.done_res = 1'b1;
                                    res.status   = STATUS_OK;
                                end
                                else
                                begin
                                    phase_next     = PH_READ;
                                    res.send_valid = 1'b1;
                                    res.send_byte  = CODE_ENQ;
                                end
                            end
                            KIND_WRITE:
                            begin
                                res.send_valid = 1'b1;
                                if (length_reg == 8'd0)
                                begin
                                    phase_next    = PH_WENQ;
                                    res.send_byte = CODE_ENQ;
                                end
                                else
                                begin
                                    phase_next    = PH_WPAY;
                                    res.send_byte = item.payload_byte;
                                end
                            end
                            default:
                            begin
                                phase_next   = PH_IDLE;
                                res.done_res = 1'b1;
                                res.status   = STATUS_UNKNOWN_CMD;
                            end
                        endcase
                    end
                    else
                    begin
                        try_next = try_inc;
                        if (try_inc >= cfg.try_limit)
                        begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                            res.status   = STATUS_HS_FAIL;
                        end
                        else
                        begin
                            phase_next     = PH_STX;
                            res.send_valid = 1'b1;
                            res.send_byte  = CODE_STX;
                        end
                    end
                end
                PH_READ:
                begin
                    res.read_valid = 1'b1;
                    res.read_data  = item.received_byte;
                    res.read_index = pos_reg;
                    if (pos_inc >= {1'b0, length_reg})
                    begin
                        // Last reply byte carries the checksum.
                        phase_next      = PH_IDLE;
                        res.done_res    = 1'b1;
                        res.status      = STATUS_OK;
                        res.checksum_ok = (item.received_byte == expect_sum);
                    end
                    else
                    begin
                        sum_next       = sum_reg + item.received_byte;
                        pos_next       = pos_inc[7:0];
                        res.send_valid = 1'b1;
                        res.send_byte  = CODE_ENQ;
                    end
                end
                PH_WPAY:
                begin
                    pos_next       = pos_inc[7:0];
                    res.send_valid = 1'b1;
                    if (pos_inc >= {1'b0, length_reg})
                    begin
                        phase_next    = PH_WENQ;
                        res.send_byte = CODE_ENQ;
                    end
                    else
                    begin
                        res.send_byte = item.payload_byte;
                    end
                end
                PH_WENQ:
                begin
                    phase_next   = PH_IDLE;
                    res.done_res = 1'b1;
                    res.status   = (item.received_byte == CODE_ACK) ? STATUS_OK : STATUS_NO_ACK;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Command state, updated once per beat that moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            try_reg     <= '0;
            pos_reg     <= '0;
            length_reg  <= '0;
            kind_reg    <= KIND_READ;
            command_reg <= '0;
            sum_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            try_reg     <= try_next;
            pos_reg     <= pos_next;
            length_reg  <= length_next;
            kind_reg    <= kind_next;
            command_reg <= command_next;
            sum_reg     <= sum_next;
        end
    end

endmodule

FILE: src/spi_command_handshake_master.sv
// ----------------------------------------------------------------------------
// SPI command handshake master
// Sequences the STX/command/ENQ handshake, read replies and write payloads.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Beat contents
//  ---------+----------------------+----------------------------------------------
//  in       | in_valid / in_stall  | func, command_byte, byte_count, received_byte,
//           |                      | payload_byte
//  out      | out_valid / out_stall| send_valid, send_byte, read_valid, read_data,
//           |                      | read_index, done_res, status, checksum_ok
//  cfg      | APB psel/penable     | command codes, handshake try limit
//
//  One beat is accepted every cycle while in_stall is low; each gives exactly one
//  result beat, by way of the input register, then the result register.
//  The sequencer state advances when a beat moves from the input register
//  into the result register, so the next beat sees it in the following cycle.
//  Reset puts the sequencer in idle and the registers at their defaults; no
//  clearing pass is needed.
//  A stalled result holds the result register; in_stall rises only when both
//  the input register and the result register are full.
//
module spi_command_handshake_master
#(
    parameter logic [7:0] MAX_LEN = spicmd_pkg::MAX_LENGTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Input beats.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  command_byte,
    input  logic [7:0]  byte_count,
    input  logic [7:0]  received_byte,
    input  logic [7:0]  payload_byte,
    // Result beats.
    output logic        out_valid,
    input  logic        out_stall,
    output logic        send_valid,
    output logic [7:0]  send_byte,
    output logic        read_valid,
    output logic [7:0]  read_data,
    output logic [7:0]  read_index,
    output logic        done_res,
    output logic [1:0]  status,
    output logic        checksum_ok,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import spicmd_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t step_res;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;
    logic    fire;
    logic    in_accept;

    // The result register can take a new beat when empty or being drained.
    assign advance   = !res_valid_reg || !out_stall;
    assign fire      = item_valid_reg && advance;
    assign in_stall  = item_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    spicmd_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spicmd_step
    #(
        .MAX_LEN (MAX_LEN)
    )
    u_step
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .cfg   (cfg),
        .item  (item_reg),
        .res   (step_res)
    );

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.func          <= func;
            item_reg.command_byte  <= command_byte;
            item_reg.byte_count    <= byte_count;
            item_reg.received_byte <= received_byte;
            item_reg.payload_byte  <= payload_byte;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= item_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid   = res_valid_reg;
    assign send_valid  = res_reg.send_valid;
    assign send_byte   = res_reg.send_byte;
    assign read_valid  = res_reg.read_valid;
    assign read_data   = res_reg.read_data;
    assign read_index  = res_reg.read_index;
    assign done_res    = res_reg.done_res;
    assign status      = res_reg.status;
    assign checksum_ok = res_reg.checksum_ok;

endmodule

FILE: src/spicmd_checker.sv
// ----------------------------------------------------------------------------
// SPI command master checker
// Port-level assertions on the result beats, bound to the top level.
// ----------------------------------------------------------------------------
module spicmd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       send_valid,
    input logic [7:0] send_byte,
    input logic       read_valid,
    input logic [7:0] read_data,
    input logic [7:0] read_index,
    input logic       done_res,
    input logic [1:0] status,
    input logic       checksum_ok
);
    import spicmd_pkg::*;

    // A stalled result beat stays and keeps its contents.
    property p_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(send_byte) && $stable(status)
            && $stable(read_data) && $stable(done_res);
    endproperty
    a_hold: assert property (p_hold) else $error("stalled result beat changed");

    // A finished command sends nothing further.
    property p_done_no_send;
        @(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !send_valid && send_byte == 8'd0;
    endproperty
    a_done_no_send: assert property (p_done_no_send)
        else $error("send request on a finished command");

    // Status and checksum flag are zero while the command runs.
    property p_status_idle;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> status == STATUS_OK && !checksum_ok;
    endproperty
    a_status_idle: assert property (p_status_idle)
        else $error("status reported before completion");

    // A good checksum is reported only with the last reply byte.
    property p_checksum_read;
        @(posedge clk) disable iff (!rst_n)
        out_valid && checksum_ok |-> read_valid && done_res && status == STATUS_OK;
    endproperty
    a_checksum_read: assert property (p_checksum_read)
        else $error("checksum flag outside a finished read");

    // Reply fields are zero when no reply byte is handed back.
    property p_read_zero;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !read_valid |-> read_data == 8'd0 && read_index == 8'd0;
    endproperty
    a_read_zero: assert property (p_read_zero)
        else $error("reply fields set without a reply byte");

endmodule

bind spi_command_handshake_master spicmd_checker u_spicmd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .send_valid  (send_valid),
    .send_byte   (send_byte),
    .read_valid  (read_valid),
    .read_data   (read_data),
    .read_index  (read_index),
    .done_res    (done_res),
    .status      (status),
    .checksum_ok (checksum_ok)
);

FILE: tb/tb_spi_command_handshake_master.sv
// ----------------------------------------------------------------------------
// Testbench for the SPI command handshake master
// Drives start and exchange beats with random gaps and output stalls, predicts
// every result beat with a cycle-free sequencer model, and compares each
// accepted result field by field. A directed table opens the run, followed by
// random well-formed commands under several command-code and try-limit settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_spi_command_handshake_master;

    import spicmd_pkg::*;

    // Random beats per configuration setting, and the drain wait limit.
    localparam int SETTING_BEATS = 200;
    localparam int DRAIN_LIMIT   = 200000;

    // Sequencer phases and latched command kinds of the predictor.
    typedef enum logic [2:0] {
        SEQ_IDLE, SEQ_STX, SEQ_CMD, SEQ_ENQ, SEQ_READ, SEQ_WPAY, SEQ_WENQ
    } seq_phase_e;

    typedef enum logic [1:0] {
        CMD_READ, CMD_WRITE, CMD_OTHER
    } cmd_kind_e;

    // One row of the directed table.
    typedef struct packed {
        item_t   beat;
        logic    typed;
        result_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [7:0]  command_byte;
    logic [7:0]  byte_count;
    logic [7:0]  received_byte;
    logic [7:0]  payload_byte;
    logic        out_valid;
    logic        out_stall;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        read_valid;
    logic [7:0]  read_data;
    logic [7:0]  read_index;
    logic        done_res;
    logic [1:0]  status;
    logic        checksum_ok;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state and its copy of the configuration.
    cfg_t        model_cfg;
    seq_phase_e  seq_phase;
    cmd_kind_e   cur_kind;
    logic [7:0]  cur_cmd;
    logic [12:0] tries;
    logic [8:0]  pos;
    logic [7:0]  act_len;
    logic [7:0]  reply_sum;

    result_t     expected_q[$];
    dir_row_t    dir_rows[$];

    int          errors;
    int          beats_in;
    int          results_seen;
    int          status_seen[4];
    int          good_checksums;
    int          settings_run;
    int          calm_left;

    spi_command_handshake_master DUT (.*);

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog on the whole run.
    initial
    begin
        #10_000_000;
        $display("FAIL spi_command_handshake_master");
        $finish;
    end

    // Gap length: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic item_t mk_item(input logic f, input logic [7:0] c, input logic [7:0] n,
                                      input logic [7:0] rx, input logic [7:0] pay);
        item_t it;
        it.func          = f;
        it.command_byte  = c;
        it.byte_count    = n;
        it.received_byte = rx;
        it.payload_byte  = pay;
        return it;
    endfunction

    function automatic result_t mk_res(input logic sv, input logic [7:0] sb, input logic rv,
                                       input logic [7:0] rd, input logic [7:0] ri,
                                       input logic dn, input logic [1:0] st, input logic ck);
        result_t r;
        r.send_valid  = sv;
        r.send_byte   = sb;
        r.read_valid  = rv;
        r.read_data   = rd;
        r.read_index  = ri;
        r.done_res    = dn;
        r.status      = st;
        r.checksum_ok = ck;
        return r;
    endfunction

    function automatic void reset_sequencer_model();
        model_cfg.read_code   = RST_READ_CODE;
        model_cfg.write1_code = RST_WRITE1_CODE;
        model_cfg.write2_code = RST_WRITE2_CODE;
        model_cfg.try_limit   = RST_TRY_LIMIT;
        seq_phase = SEQ_IDLE;
        cur_kind  = CMD_READ;
        cur_cmd   = '0;
        tries     = '0;
        pos       = '0;
        act_len   = '0;
        reply_sum = '0;
    endfunction

    // Advance the sequencer model by one accepted beat and return its result beat.
    function automatic result_t predict_sequencer(input item_t it);
        result_t    r;
        logic [7:0] sum_want;
        r = '0;
        if (it.func == FUNC_START)
        begin
            // A start while a command is running is dropped.
            if (seq_phase != SEQ_IDLE)
                return r;
            cur_cmd = it.command_byte;
            if (it.command_byte == model_cfg.read_code)
                cur_kind = CMD_READ;
            else if (it.command_byte == model_cfg.write1_code ||
                     it.command_byte == model_cfg.write2_code)
                cur_kind = CMD_WRITE;
            else
                cur_kind = CMD_OTHER;
            act_len   = (it.byte_count > MAX_LENGTH) ? MAX_LENGTH : it.byte_count;
            tries     = '0;
            pos       = '0;
            reply_sum = '0;
            seq_phase = SEQ_STX;
            r.send_valid = 1'b1;
            r.send_byte  = CODE_STX;
            return r;
        end

        case (seq_phase)
            SEQ_STX:
            begin
                seq_phase    = SEQ_CMD;
                r.send_valid = 1'b1;
                r.send_byte  = cur_cmd;
            end
            SEQ_CMD:
            begin
                seq_phase    = SEQ_ENQ;
                r.send_valid = 1'b1;
                r.send_byte  = CODE_ENQ;
            end
            SEQ_ENQ:
            begin
                if (it.received_byte == CODE_ACK)
                begin
                    pos       = '0;
                    reply_sum = '0;
                    if (cur_kind == CMD_READ && act_len == 8'd0)
                    begin
                        r.done_res = 1'b1;
                        r.status   = STATUS_OK;
                        seq_phase  = SEQ_IDLE;
                    end
                    else if (cur_kind == CMD_READ)
                    begin
                        seq_phase    = SEQ_READ;
                        r.send_valid = 1'b1;
                        r.send_byte  = CODE_ENQ;
                    end
                    else if (cur_kind == CMD_WRITE && act_len == 8'd0)
                    begin
                        seq_phase    = SEQ_WENQ;
                        r.send_valid = 1'b1;
                        r.send_byte  = CODE_ENQ;
                    end
                    else if (cur_kind == CMD_WRITE)
                    begin
                        seq_phase    = SEQ_WPAY;
                        r.send_valid = 1'b1;
                        r.send_byte  = it.payload_byte;
                    end
                    else
                    begin
                        r.done_res = 1'b1;
                        r.status   = STATUS_UNKNOWN_CMD;
                        seq_phase  = SEQ_IDLE;
                    end
                end
                else
                begin
                    // No ACK: retry the handshake until the try limit is used up.
                    tries = tries + 13'd1;
                    if (tries >= model_cfg.try_limit)
                    begin
                        r.done_res = 1'b1;
                        r.status   = STATUS_HS_FAIL;
                        seq_phase  = SEQ_IDLE;
                    end
                    else
                    begin
                        seq_phase    = SEQ_STX;
                        r.send_valid = 1'b1;
                        r.send_byte  = CODE_STX;
                    end
                end
            end
            SEQ_READ:
            begin
                r.read_valid = 1'b1;
                r.read_data  = it.received_byte;
                r.read_index = pos[7:0];
                if (pos + 9'd1 >= {1'b0, act_len})
                begin
                    // Last reply byte carries 0xFF minus the sum of the others.
                    sum_want      = CHECKSUM_BASE - reply_sum;
                    r.done_res    = 1'b1;
                    r.status      = STATUS_OK;
                    r.checksum_ok = (it.received_byte == sum_want);
                    seq_phase     = SEQ_IDLE;
                end
                else
                begin
                    reply_sum    = reply_sum + it.received_byte;
                    pos          = pos + 9'd1;
                    r.send_valid = 1'b1;
                    r.send_byte  = CODE_ENQ;
                end
            end
            SEQ_WPAY:
            begin
                pos          = pos + 9'd1;
                r.send_valid = 1'b1;
                if (pos >= {1'b0, act_len})
                begin
                    seq_phase   = SEQ_WENQ;
                    r.send_byte = CODE_ENQ;
                end
                else
                begin
                    r.send_byte = it.payload_byte;
                end
            end
            SEQ_WENQ:
            begin
                r.done_res = 1'b1;
                r.status   = (it.received_byte == CODE_ACK) ? STATUS_OK : STATUS_NO_ACK;
                seq_phase  = SEQ_IDLE;
            end
            default:
            begin
                seq_phase = SEQ_IDLE;
            end
        endcase
        return r;
    endfunction

    // Drive one input beat after an optional gap and hold it until accepted.
    task automatic send_beat(input item_t it, input logic typed, input result_t want);
        int      gap;
        result_t model_res;
        if (calm_left > 0)
        begin
            calm_left--;
            gap = 0;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 63) == 0)
                calm_left = $urandom_range(30, 120);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        func          <= it.func;
        command_byte  <= it.command_byte;
        byte_count    <= it.byte_count;
        received_byte <= it.received_byte;
        payload_byte  <= it.payload_byte;
        do
            @(posedge clk);
        while (in_stall);
        model_res = predict_sequencer(it);
        expected_q.push_back(typed ? want : model_res);
        beats_in++;
    endtask

    // Hold the sender until every expected result beat has come back.
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_READ_CODE:   model_cfg.read_code   = val[7:0];
            REG_WRITE1_CODE: model_cfg.write1_code = val[7:0];
            REG_WRITE2_CODE: model_cfg.write2_code = val[7:0];
            REG_TRY_LIMIT:   model_cfg.try_limit   = val[12:0];
            default:         ;
        endcase
    endtask

    // New setting: wait for the block to go quiet, then write all registers.
    task automatic apply_setting(input logic [7:0] rd_code, input logic [7:0] wr1_code,
                                 input logic [7:0] wr2_code, input logic [12:0] limit);
        drain_results();
        apb_write(REG_READ_CODE, {24'd0, rd_code});
        apb_write(REG_WRITE1_CODE, {24'd0, wr1_code});
        apb_write(REG_WRITE2_CODE, {24'd0, wr2_code});
        apb_write(REG_TRY_LIMIT, {19'd0, limit});
        settings_run++;
    endtask

    function automatic logic [7:0] pick_command();
        int r;
        r = $urandom_range(0, 7);
        if (r < 3)
            return model_cfg.read_code;
        if (r < 5)
            return model_cfg.write1_code;
        if (r == 5)
            return model_cfg.write2_code;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 8'($urandom_range(0, 4));
        if (r < 85)
            return 8'($urandom_range(5, 16));
        if (r < 95)
            return 8'($urandom_range(17, 254));
        return 8'hFF;
    endfunction

    function automatic item_t random_beat(input logic f);
        return mk_item(f, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endfunction

    // One full command with random content; returns the beats the block acted on.
    task automatic run_command(output int acted);
        item_t it;
        acted = 0;
        // Occasional exchange while idle, which the block ignores.
        if ($urandom_range(0, 24) == 0)
            send_beat(random_beat(FUNC_EXCHANGE), 1'b0, '0);
        it = random_beat(FUNC_START);
        it.command_byte = pick_command();
        it.byte_count   = pick_length();
        send_beat(it, 1'b0, '0);
        acted++;
        while (seq_phase != SEQ_IDLE)
        begin
            // Occasional start while busy, also ignored.
            if ($urandom_range(0, 32) == 0)
                send_beat(random_beat(FUNC_START), 1'b0, '0);
            it = random_beat(FUNC_EXCHANGE);
            case (seq_phase)
                SEQ_ENQ:
                    if ($urandom_range(0, 99) < 65)
                        it.received_byte = CODE_ACK;
                SEQ_READ:
                    if (pos + 9'd1 >= {1'b0, act_len} && $urandom_range(0, 1) == 1)
                        it.received_byte = CHECKSUM_BASE - reply_sum;
                SEQ_WENQ:
                    if ($urandom_range(0, 99) < 75)
                        it.received_byte = CODE_ACK;
                default:
                    ;
            endcase
            send_beat(it, 1'b0, '0);
            acted++;
        end
    endtask

    task automatic run_random(input int target);
        int acted;
        int total;
        total = 0;
        while (total < target)
        begin
            run_command(acted);
            total += acted;
            if ($urandom_range(0, 99) == 0)
                drain_results();
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // Result side: random stalls, with stall-free stretches.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                @(negedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 80) - 1) @(negedge clk);
            end
            else
            begin
                repeat ($urandom_range(10, 40))
                begin
                    n = pick_gap();
                    @(negedge clk);
                    out_stall <= (n > 0);
                    if (n > 1)
                        repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        result_t got_res;
        result_t want_res;
        if (rst_n && out_valid && !out_stall)
        begin
            got_res = mk_res(send_valid, send_byte, read_valid, read_data, read_index,
                             done_res, status, checksum_ok);
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual %0h", $time, got_res);
                errors++;
            end
            else
            begin
                want_res = expected_q.pop_front();
                check_field("send_valid", want_res.send_valid, got_res.send_valid);
                check_field("send_byte", want_res.send_byte, got_res.send_byte);
                check_field("read_valid", want_res.read_valid, got_res.read_valid);
                check_field("read_data", want_res.read_data, got_res.read_data);
                check_field("read_index", want_res.read_index, got_res.read_index);
                check_field("done_res", want_res.done_res, got_res.done_res);
                check_field("status", want_res.status, got_res.status);
                check_field("checksum_ok", want_res.checksum_ok, got_res.checksum_ok);
                if (want_res.done_res)
                begin
                    status_seen[want_res.status]++;
                    if (want_res.checksum_ok)
                        good_checksums++;
                end
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        dir_row_t row;
        errors         = 0;
        beats_in       = 0;
        results_seen   = 0;
        good_checksums = 0;
        settings_run   = 1;
        calm_left      = 0;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = FUNC_START;
        command_byte  = '0;
        byte_count    = '0;
        received_byte = '0;
        payload_byte  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        reset_sequencer_model();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, run with the reset codes (read 1, writes 2 and 3).
        // Exchange while idle is ignored.
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'hA5, 8'h5A, CODE_ACK, 8'hFF), 1'b1,
                            result_t'('0)});
        // Three-byte read with a good checksum; a start while busy is ignored.
        dir_rows.push_back({mk_item(FUNC_START, 8'd1, 8'd3, 8'h00, 8'h00), 1'b1,
                            mk_res(1'b1, CODE_STX, 1'b0, 8'd0, 8'd0, 1'b0, STATUS_OK, 1'b0)});
        dir_rows.push_back({mk_item(FUNC_START, 8'd2, 8'd0, 8'h00, 8'h00), 1'b1,
                            result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'hFF, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, CODE_ACK, 8'h00), 1'b0,
                            result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'h10, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'h20, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'hCF, 8'h00), 1'b1,
                            mk_res(1'b0, 8'd0, 1'b1, 8'hCF, 8'd2, 1'b1, STATUS_OK, 1'b1)});
        // Two-byte write with one handshake retry and no final ACK.
        dir_rows.push_back({mk_item(FUNC_START, 8'd2, 8'd2, 8'h00, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'hFF, 8'hFF, 8'h00, 8'h00), 1'b0,
                            result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'h15, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, CODE_ACK, 8'hFF), 1'b0,
                            result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                            mk_res(1'b0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b1, STATUS_NO_ACK, 1'b0)});
        // Unknown command of saturated length fails after the handshake.
        dir_rows.push_back({mk_item(FUNC_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, CODE_ACK, 8'h00), 1'b1,
                            mk_res(1'b0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b1, STATUS_UNKNOWN_CMD, 1'b0)});
        // Zero-length read finishes right after the handshake.
        dir_rows.push_back({mk_item(FUNC_START, 8'd1, 8'd0, 8'h00, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, result_t'('0)});
        dir_rows.push_back({mk_item(FUNC_EXCHANGE, 8'h00, 8'h00, CODE_ACK, 8'h00), 1'b1,
                            mk_res(1'b0, 8'd0, 1'b0, 8'd0, 8'd0, 1'b1, STATUS_OK, 1'b0)});

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_beat(row.beat, row.typed, row.want);
        end

        // Random commands under several settings.
        run_random(SETTING_BEATS);
        // Read code 0x00, write codes 0xFF and 0x80, single try.
        apply_setting(8'h00, 8'hFF, 8'h80, 13'd1);
        run_random(SETTING_BEATS);
        // All codes equal: read takes priority; try limit at its reset value.
        apply_setting(8'h07, 8'h07, 8'h07, 13'd4096);
        run_random(SETTING_BEATS);
        // Try limit of zero acts as a single try; both write codes equal.
        apply_setting(8'hFF, 8'h10, 8'h10, 13'd0);
        run_random(SETTING_BEATS);
        // Read code shadows the second write code.
        apply_setting(8'h55, 8'hAA, 8'h55, 13'd3);
        run_random(SETTING_BEATS);
        apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 13'($urandom_range(1, 8)));
        run_random(SETTING_BEATS);

        drain_results();
        if (expected_q.size() != 0)
        begin
            $display("%0t: %0d result beats never arrived", $time, expected_q.size());
            errors++;
        end

        $display("Run covered %0d input beats and %0d result beats over %0d settings.",
                 beats_in, results_seen, settings_run);
        $display({"Commands finished: %0d ok, %0d handshake fail, %0d no ACK, ",
                  "%0d unknown; %0d good checksums."},
                 status_seen[STATUS_OK], status_seen[STATUS_HS_FAIL], status_seen[STATUS_NO_ACK],
                 status_seen[STATUS_UNKNOWN_CMD], good_checksums);
        if (errors == 0)
            $display("PASS spi_command_handshake_master");
        else
            $display("FAIL spi_command_handshake_master");
        $finish;
    end

endmodule

FILE: sim.f
src/spicmd_pkg.sv
src/spicmd_cfg_regs.sv
src/spicmd_step.sv
src/spi_command_handshake_master.sv
src/spicmd_checker.sv
tb/tb_spi_command_handshake_master.sv
